@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the pose inverse transform.
// Expect clk and rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock while out of reset
`define QIT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("qit assertion failed");

// check a same-cycle implication while out of reset
`define QIT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("qit implication failed");

`endif

@@ src/qit_pkg.sv @@
// Package for the pose inverse transform: widths, constants, shared types.
// No dependencies.
`timescale 1ns / 1ps

package qit_pkg;

    localparam int QUAT_W  = 32;
    localparam int QFRAC   = 30;
    localparam int POS_W   = 32;
    localparam int SEC_W   = 32;
    localparam int NSEC_W  = 30;
    localparam int TIME_W  = 62;

    // doubled quaternion product after rounding to QFRAC fraction bits
    localparam int QP_W    = 2 * QUAT_W - (QFRAC - 1);
    // rotation matrix entry
    localparam int ENT_W   = QP_W + 2;
    // entry split into an unsigned low and a signed high part
    localparam int LO_W    = ENT_W / 2;
    localparam int HI_W    = ENT_W - LO_W;
    localparam int PP_W    = HI_W + POS_W + 1;
    localparam int SUM_W   = PP_W + 2;
    localparam int TOT_W   = SUM_W + LO_W + 1;
    localparam int RND_W   = TOT_W - QFRAC;

    // cycles from accepted beat to result strobe
    localparam int LAT     = 6;

    localparam logic [TIME_W-1:0] NS_PER_SEC = TIME_W'(64'd1000000000);

    typedef struct packed {
        logic signed [POS_W-1:0] value;
        logic                    sat;
    } center_t;

endpackage

@@ src/qit_center.sv @@
// One component of -(R^T t): split products, sums, negation with rounding, clipping.
// Depends on qit_pkg.
`timescale 1ns / 1ps

module qit_center (
    input  logic                                clk,
    input  logic signed [qit_pkg::ENT_W-1:0]    ent [3],
    input  logic signed [qit_pkg::POS_W-1:0]    pos [3],
    output qit_pkg::center_t                    res
);

    localparam logic signed [qit_pkg::TOT_W-1:0] HALF =
        qit_pkg::TOT_W'(1) <<< (qit_pkg::QFRAC - 1);
    localparam logic signed [qit_pkg::RND_W-1:0] POS_MAX =
        qit_pkg::RND_W'({1'b0, {(qit_pkg::POS_W - 1){1'b1}}});
    localparam logic signed [qit_pkg::RND_W-1:0] POS_MIN = -POS_MAX - qit_pkg::RND_W'(1);

    logic signed [qit_pkg::PP_W-1:0]  pp_lo_reg [3];
    logic signed [qit_pkg::PP_W-1:0]  pp_lo_next [3];
    logic signed [qit_pkg::PP_W-1:0]  pp_hi_reg [3];
    logic signed [qit_pkg::PP_W-1:0]  pp_hi_next [3];
    logic signed [qit_pkg::SUM_W-1:0] lo_sum_reg;
    logic signed [qit_pkg::SUM_W-1:0] lo_sum_next;
    logic signed [qit_pkg::SUM_W-1:0] hi_sum_reg;
    logic signed [qit_pkg::SUM_W-1:0] hi_sum_next;
    logic signed [qit_pkg::TOT_W-1:0] neg_reg;
    logic signed [qit_pkg::TOT_W-1:0] neg_next;
    qit_pkg::center_t                 res_reg;
    qit_pkg::center_t                 res_next;
    logic signed [qit_pkg::RND_W-1:0] rnd;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            pp_lo_next[i] = $signed({1'b0, ent[i][qit_pkg::LO_W-1:0]}) * pos[i];
            pp_hi_next[i] = $signed(ent[i][qit_pkg::ENT_W-1:qit_pkg::LO_W]) * pos[i];
        end
    end

    always_comb
    begin
        lo_sum_next = qit_pkg::SUM_W'(pp_lo_reg[0]) + qit_pkg::SUM_W'(pp_lo_reg[1])
                    + qit_pkg::SUM_W'(pp_lo_reg[2]);
        hi_sum_next = qit_pkg::SUM_W'(pp_hi_reg[0]) + qit_pkg::SUM_W'(pp_hi_reg[1])
                    + qit_pkg::SUM_W'(pp_hi_reg[2]);
    end

    always_comb
    begin
        neg_next = HALF - ((qit_pkg::TOT_W'(hi_sum_reg) <<< qit_pkg::LO_W)
                           + qit_pkg::TOT_W'(lo_sum_reg));
    end

    always_comb
    begin
        rnd = $signed(neg_reg[qit_pkg::TOT_W-1:qit_pkg::QFRAC]);
        if (rnd > POS_MAX)
        begin
            res_next.value = POS_MAX[qit_pkg::POS_W-1:0];
            res_next.sat   = 1'b1;
        end
        else if (rnd < POS_MIN)
        begin
            res_next.value = POS_MIN[qit_pkg::POS_W-1:0];
            res_next.sat   = 1'b1;
        end
        else
        begin
            res_next.value = rnd[qit_pkg::POS_W-1:0];
            res_next.sat   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        pp_lo_reg  <= pp_lo_next;
        pp_hi_reg  <= pp_hi_next;
        lo_sum_reg <= lo_sum_next;
        hi_sum_reg <= hi_sum_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
    end

    assign res = res_reg;

endmodule

@@ src/quaternion_inverse_translate.sv @@
// Pose inverse transform: center = -(R(q)^T t), stamp as whole nanoseconds.
// done is the last stage valid bit and rises together with the registered result beat.
// Throughput: one beat per cycle; busy stays low, the six register stages never stall.
// Reset (rst_n, async, active low) clears only the stage valid bits.
// Depends on qit_pkg, qit_center and assert_macros.svh.
`timescale 1ns / 1ps

module quaternion_inverse_translate (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic signed [qit_pkg::QUAT_W-1:0]       quat_w,
    input  logic signed [qit_pkg::QUAT_W-1:0]       quat_x,
    input  logic signed [qit_pkg::QUAT_W-1:0]       quat_y,
    input  logic signed [qit_pkg::QUAT_W-1:0]       quat_z,
    input  logic signed [qit_pkg::POS_W-1:0]        pos_x,
    input  logic signed [qit_pkg::POS_W-1:0]        pos_y,
    input  logic signed [qit_pkg::POS_W-1:0]        pos_z,
    input  logic        [qit_pkg::SEC_W-1:0]        stamp_sec,
    input  logic        [qit_pkg::NSEC_W-1:0]       stamp_nsec,
    output logic                                    done,
    output logic signed [qit_pkg::POS_W-1:0]        center_x,
    output logic signed [qit_pkg::POS_W-1:0]        center_y,
    output logic signed [qit_pkg::POS_W-1:0]        center_z,
    output logic        [qit_pkg::TIME_W-1:0]       time_ns,
    output logic                                    saturated
);

    `include "assert_macros.svh"

    localparam logic signed [qit_pkg::ENT_W-1:0] ONE =
        qit_pkg::ENT_W'(1) <<< qit_pkg::QFRAC;

    function automatic logic signed [qit_pkg::QP_W-1:0] qprod2(
        input logic signed [qit_pkg::QUAT_W-1:0] a,
        input logic signed [qit_pkg::QUAT_W-1:0] b
    );
        logic signed [2*qit_pkg::QUAT_W-1:0] p;
        p = a * b + ((2*qit_pkg::QUAT_W)'(1) <<< (qit_pkg::QFRAC - 2));
        return $signed(p[2*qit_pkg::QUAT_W-1:qit_pkg::QFRAC-1]);
    endfunction

    logic                              accept;
    logic [qit_pkg::LAT-1:0]           vld_reg;
    logic [qit_pkg::LAT-1:0]           vld_next;

    // stage 1: quaternion products, positions, seconds product
    logic signed [qit_pkg::QP_W-1:0]   xx_reg, yy_reg, zz_reg, xy_reg, xz_reg;
    logic signed [qit_pkg::QP_W-1:0]   yz_reg, wx_reg, wy_reg, wz_reg;
    logic signed [qit_pkg::POS_W-1:0]  pos1_reg [3];
    logic        [qit_pkg::TIME_W-1:0] tmul_reg;
    logic        [qit_pkg::NSEC_W-1:0] nsec_reg;

    // stage 2: matrix entries, indexed [column][row]
    logic signed [qit_pkg::ENT_W-1:0]  ent_reg [3][3];
    logic signed [qit_pkg::ENT_W-1:0]  ent_next [3][3];
    logic signed [qit_pkg::POS_W-1:0]  pos2_reg [3];
    logic        [qit_pkg::TIME_W-1:0] time_reg [qit_pkg::LAT-1];
    logic        [qit_pkg::TIME_W-1:0] time_next;

    qit_pkg::center_t                  cres [3];

    assign busy     = 1'b0;
    assign accept   = start && !busy;
    assign vld_next = {vld_reg[qit_pkg::LAT-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        xx_reg      <= qprod2(quat_x, quat_x);
        yy_reg      <= qprod2(quat_y, quat_y);
        zz_reg      <= qprod2(quat_z, quat_z);
        xy_reg      <= qprod2(quat_x, quat_y);
        xz_reg      <= qprod2(quat_x, quat_z);
        yz_reg      <= qprod2(quat_y, quat_z);
        wx_reg      <= qprod2(quat_w, quat_x);
        wy_reg      <= qprod2(quat_w, quat_y);
        wz_reg      <= qprod2(quat_w, quat_z);
        pos1_reg[0] <= pos_x;
        pos1_reg[1] <= pos_y;
        pos1_reg[2] <= pos_z;
        tmul_reg    <= qit_pkg::TIME_W'(stamp_sec) * qit_pkg::NS_PER_SEC;
        nsec_reg    <= stamp_nsec;
    end

    always_comb
    begin
        ent_next[0][0] = ONE - (qit_pkg::ENT_W'(yy_reg) + qit_pkg::ENT_W'(zz_reg));
        ent_next[0][1] = qit_pkg::ENT_W'(xy_reg) + qit_pkg::ENT_W'(wz_reg);
        ent_next[0][2] = qit_pkg::ENT_W'(xz_reg) - qit_pkg::ENT_W'(wy_reg);
        ent_next[1][0] = qit_pkg::ENT_W'(xy_reg) - qit_pkg::ENT_W'(wz_reg);
        ent_next[1][1] = ONE - (qit_pkg::ENT_W'(xx_reg) + qit_pkg::ENT_W'(zz_reg));
        ent_next[1][2] = qit_pkg::ENT_W'(yz_reg) + qit_pkg::ENT_W'(wx_reg);
        ent_next[2][0] = qit_pkg::ENT_W'(xz_reg) + qit_pkg::ENT_W'(wy_reg);
        ent_next[2][1] = qit_pkg::ENT_W'(yz_reg) - qit_pkg::ENT_W'(wx_reg);
        ent_next[2][2] = ONE - (qit_pkg::ENT_W'(xx_reg) + qit_pkg::ENT_W'(yy_reg));
        time_next      = tmul_reg + qit_pkg::TIME_W'(nsec_reg);
    end

    always_ff @(posedge clk)
    begin
        ent_reg     <= ent_next;
        pos2_reg    <= pos1_reg;
        time_reg[0] <= time_next;
        for (int i = 1; i < qit_pkg::LAT - 1; i++)
        begin
            time_reg[i] <= time_reg[i-1];
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_center
        qit_center u_center (
            .clk (clk),
            .ent (ent_reg[c]),
            .pos (pos2_reg),
            .res (cres[c])
        );
    end

    assign done      = vld_reg[qit_pkg::LAT-1];
    assign center_x  = cres[0].value;
    assign center_y  = cres[1].value;
    assign center_z  = cres[2].value;
    assign time_ns   = time_reg[qit_pkg::LAT-2];
    assign saturated = cres[0].sat | cres[1].sat | cres[2].sat;

    `QIT_ASSERT(a_done_source, !done || $past(accept, qit_pkg::LAT))
    `QIT_ASSERT_IMPL(a_sat_clip, done && saturated,
        cres[0].value == {1'b0, {(qit_pkg::POS_W-1){1'b1}}} ||
        cres[0].value == {1'b1, {(qit_pkg::POS_W-1){1'b0}}} ||
        cres[1].value == {1'b0, {(qit_pkg::POS_W-1){1'b1}}} ||
        cres[1].value == {1'b1, {(qit_pkg::POS_W-1){1'b0}}} ||
        cres[2].value == {1'b0, {(qit_pkg::POS_W-1){1'b1}}} ||
        cres[2].value == {1'b1, {(qit_pkg::POS_W-1){1'b0}}})

endmodule

@@ tb/quaternion_inverse_translate_tb.sv @@
// Testbench for quaternion_inverse_translate: directed and random poses checked against
// a scoreboard that predicts -(R^T t), the saturation flag and the stamp in nanoseconds.
// Depends on qit_pkg and the quaternion_inverse_translate RTL.
`timescale 1ns / 1ps

module quaternion_inverse_translate_tb;

    import qit_pkg::*;

    localparam logic signed [QUAT_W-1:0] Q_ONE   = 32'sh4000_0000;
    localparam logic signed [QUAT_W-1:0] Q_NEG   = 32'shC000_0000;
    localparam logic signed [QUAT_W-1:0] Q_HALF  = 32'sh2000_0000;
    localparam logic signed [QUAT_W-1:0] Q_DIAG  = 32'sd759250125;
    localparam logic signed [QUAT_W-1:0] Q_TOP   = 32'sh7FFF_FFFF;
    localparam logic signed [QUAT_W-1:0] Q_BOT   = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0]  POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [SEC_W-1:0]         SEC_MAX = '1;
    localparam logic [NSEC_W-1:0]        NSEC_TOP = '1;
    localparam logic [NSEC_W-1:0]        NSEC_LAST = 30'd999999999;
    localparam logic [NSEC_W-1:0]        NSEC_ONE_SEC = 30'd1000000000;
    localparam int N_RANDOM    = 1830;
    localparam int QUIET_TAIL  = 200;
    localparam int STALL_LIMIT = 1000;

    typedef logic signed [127:0] acc_t;

    typedef struct packed {
        logic signed [QUAT_W-1:0] qw;
        logic signed [QUAT_W-1:0] qx;
        logic signed [QUAT_W-1:0] qy;
        logic signed [QUAT_W-1:0] qz;
        logic signed [POS_W-1:0]  px;
        logic signed [POS_W-1:0]  py;
        logic signed [POS_W-1:0]  pz;
        logic [SEC_W-1:0]         sec;
        logic [NSEC_W-1:0]        nsec;
    } pose_t;

    typedef struct packed {
        logic signed [POS_W-1:0] cx;
        logic signed [POS_W-1:0] cy;
        logic signed [POS_W-1:0] cz;
        logic [TIME_W-1:0]       time_ns;
        logic                    sat;
    } center_res_t;

    class pose_scoreboard;
        center_res_t expected_centers[$];
        int mismatch_cnt;

        function new();
            mismatch_cnt = 0;
        endfunction

        function int pending();
            return expected_centers.size();
        endfunction

        function acc_t dbl_prod(acc_t a, acc_t b);
            return (a * b + (acc_t'(1) <<< (QFRAC - 2))) >>> (QFRAC - 1);
        endfunction

        function logic signed [POS_W-1:0] rot_axis(acc_t a, acc_t b, acc_t c, acc_t tx,
                                                   acc_t ty, acc_t tz, inout logic sat);
            acc_t s;
            s = -(a * tx + b * ty + c * tz);
            s = (s + (acc_t'(1) <<< (QFRAC - 1))) >>> QFRAC;
            if (s > acc_t'(POS_MAX))
            begin
                sat = 1'b1;
                s = acc_t'(POS_MAX);
            end
            else if (s < acc_t'(POS_MIN))
            begin
                sat = 1'b1;
                s = acc_t'(POS_MIN);
            end
            return s[POS_W-1:0];
        endfunction

        function center_res_t inverse_pose(pose_t p);
            acc_t w, x, y, z, tx, ty, tz, one;
            acc_t xx, yy, zz, xy, xz, yz, wx, wy, wz;
            logic [63:0] ns;
            logic sat;
            center_res_t r;
            w = acc_t'(signed'(p.qw));
            x = acc_t'(signed'(p.qx));
            y = acc_t'(signed'(p.qy));
            z = acc_t'(signed'(p.qz));
            tx = acc_t'(signed'(p.px));
            ty = acc_t'(signed'(p.py));
            tz = acc_t'(signed'(p.pz));
            one = acc_t'(1) <<< QFRAC;
            xx = dbl_prod(x, x);
            yy = dbl_prod(y, y);
            zz = dbl_prod(z, z);
            xy = dbl_prod(x, y);
            xz = dbl_prod(x, z);
            yz = dbl_prod(y, z);
            wx = dbl_prod(w, x);
            wy = dbl_prod(w, y);
            wz = dbl_prod(w, z);
            sat = 1'b0;
            r.cx = rot_axis(one - (yy + zz), xy + wz, xz - wy, tx, ty, tz, sat);
            r.cy = rot_axis(xy - wz, one - (xx + zz), yz + wx, tx, ty, tz, sat);
            r.cz = rot_axis(xz + wy, yz - wx, one - (xx + yy), tx, ty, tz, sat);
            ns = 64'(p.sec) * 64'd1000000000 + 64'(p.nsec);
            r.time_ns = ns[TIME_W-1:0];
            r.sat = sat;
            return r;
        endfunction

        function void note_pose(pose_t p);
            expected_centers.insert(expected_centers.size(), inverse_pose(p));
        endfunction

        function void check_result(center_res_t got);
            center_res_t exp_r;
            if (expected_centers.size() == 0)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: result with no pose pending: c=(%0d,%0d,%0d) ns=%0d sat=%0b",
                             $realtime, got.cx, got.cy, got.cz, got.time_ns, got.sat);
                return;
            end
            exp_r = expected_centers.pop_front();
            if (got.cx !== exp_r.cx || got.cy !== exp_r.cy || got.cz !== exp_r.cz ||
                got.time_ns !== exp_r.time_ns || got.sat !== exp_r.sat)
            begin
                mismatch_cnt++;
                if (mismatch_cnt <= 10)
                    $display("%0t: mismatch exp c=(%0d,%0d,%0d) ns=%0d sat=%0b",
                             $realtime, exp_r.cx, exp_r.cy, exp_r.cz, exp_r.time_ns,
                             exp_r.sat, " act c=(%0d,%0d,%0d) ns=%0d sat=%0b",
                             got.cx, got.cy, got.cz, got.time_ns, got.sat);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    pose_t pose_q = '0;
    logic busy;
    logic done;
    logic signed [POS_W-1:0] center_x;
    logic signed [POS_W-1:0] center_y;
    logic signed [POS_W-1:0] center_z;
    logic [TIME_W-1:0] time_ns;
    logic saturated;
    int quiet_cycles = 0;
    pose_scoreboard sb = new();

    quaternion_inverse_translate u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .quat_w     (pose_q.qw),
        .quat_x     (pose_q.qx),
        .quat_y     (pose_q.qy),
        .quat_z     (pose_q.qz),
        .pos_x      (pose_q.px),
        .pos_y      (pose_q.py),
        .pos_z      (pose_q.pz),
        .stamp_sec  (pose_q.sec),
        .stamp_nsec (pose_q.nsec),
        .done       (done),
        .center_x   (center_x),
        .center_y   (center_y),
        .center_z   (center_z),
        .time_ns    (time_ns),
        .saturated  (saturated)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_pose(pose_q);
            if (done === 1'b1)
                sb.check_result('{center_x, center_y, center_z, time_ns, saturated});
        end
        if ((start && !busy) || done === 1'b1)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        while (quiet_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic longint span(longint lo, longint hi);
        return lo + longint'($urandom_range(32'(hi - lo)));
    endfunction

    function automatic pose_t mk_pose(logic signed [QUAT_W-1:0] w, logic signed [QUAT_W-1:0] x,
                                      logic signed [QUAT_W-1:0] y, logic signed [QUAT_W-1:0] z,
                                      logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
                                      logic signed [POS_W-1:0] pz, logic [SEC_W-1:0] sec,
                                      logic [NSEC_W-1:0] nsec);
        pose_t p;
        p = '{w, x, y, z, px, py, pz, sec, nsec};
        return p;
    endfunction

    function automatic logic signed [POS_W-1:0] rand_pos();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 55)
            return POS_W'(span(-(64'sd1 <<< 22), 64'sd1 <<< 22));
        else if (r < 80)
            return $urandom();
        else if (r < 90)
            return POS_W'(span(-(64'sd1 <<< 30), 64'sd1 <<< 30));
        case ($urandom_range(4))
            0: return POS_MIN;
            1: return POS_MAX;
            2: return '0;
            3: return -1;
            default: return 1;
        endcase
    endfunction

    function automatic logic signed [QUAT_W-1:0] rand_axis();
        case ($urandom_range(2))
            0: return Q_ONE;
            1: return Q_NEG;
            default: return '0;
        endcase
    endfunction

    function automatic pose_t random_pose();
        pose_t p;
        real a[4];
        real nrm;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 65)
        begin
            nrm = 0.0;
            for (int k = 0; k < 4; k++)
            begin
                a[k] = (real'($urandom_range(2000000)) - 1.0e6) / 1.0e6;
                nrm += a[k] * a[k];
            end
            nrm = $sqrt(nrm);
            if (nrm < 1.0e-3)
            begin
                a[0] = 1.0;
                a[1] = 0.0;
                a[2] = 0.0;
                a[3] = 0.0;
                nrm = 1.0;
            end
            p.qw = $rtoi(a[0] / nrm * 1073741824.0);
            p.qx = $rtoi(a[1] / nrm * 1073741824.0);
            p.qy = $rtoi(a[2] / nrm * 1073741824.0);
            p.qz = $rtoi(a[3] / nrm * 1073741824.0);
        end
        else if (r < 85)
        begin
            p.qw = QUAT_W'(span(-(64'sd1 <<< 30), 64'sd1 <<< 30));
            p.qx = QUAT_W'(span(-(64'sd1 <<< 30), 64'sd1 <<< 30));
            p.qy = QUAT_W'(span(-(64'sd1 <<< 30), 64'sd1 <<< 30));
            p.qz = QUAT_W'(span(-(64'sd1 <<< 30), 64'sd1 <<< 30));
        end
        else if (r < 93)
        begin
            p.qw = $urandom();
            p.qx = $urandom();
            p.qy = $urandom();
            p.qz = $urandom();
        end
        else
        begin
            p.qw = rand_axis();
            p.qx = rand_axis();
            p.qy = rand_axis();
            p.qz = rand_axis();
        end
        p.px = rand_pos();
        p.py = rand_pos();
        p.pz = rand_pos();
        r = $urandom_range(19);
        p.sec = (r == 0) ? SEC_MAX : (r == 1) ? '0 : $urandom();
        p.nsec = ($urandom_range(9) == 0) ? NSEC_W'($urandom()) : NSEC_W'(span(0, NSEC_LAST));
        return p;
    endfunction

    task automatic send_pose(pose_t p);
        pose_q <= p;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
    endtask

    // drop start and scramble the idle inputs, then wait
    task automatic idle_cycles(int n);
        start <= 1'b0;
        pose_q <= random_pose();
        repeat (n) @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic run_directed();
        send_pose(mk_pose(Q_ONE, '0, '0, '0, '0, '0, '0, '0, '0));
        send_pose(mk_pose(Q_ONE, '0, '0, '0, POS_MIN, POS_MAX, 1, SEC_MAX, NSEC_LAST));
        send_pose(mk_pose(Q_NEG, '0, '0, '0, POS_MAX, POS_MIN, -1, 1, '0));
        send_pose(mk_pose('0, Q_ONE, '0, '0, 12345678, -87654321, POS_MAX, '0, NSEC_TOP));
        send_pose(mk_pose('0, '0, Q_ONE, '0, POS_MIN, 65536, -65536, 7, 1));
        send_pose(mk_pose('0, '0, '0, Q_ONE, -3000000, 5000000, 70000, 100, 500));
        send_pose(mk_pose('0, Q_NEG, '0, '0, 1, 2, 3, 12, 13));
        send_pose(mk_pose('0, '0, Q_NEG, '0, -1, -2, -3, 14, 15));
        send_pose(mk_pose('0, '0, '0, Q_NEG, POS_MAX, POS_MAX, POS_MIN, 16, 17));
        send_pose(mk_pose(Q_DIAG, Q_DIAG, '0, '0, 1, -1, 1, 18, 19));
        send_pose(mk_pose(Q_DIAG, '0, '0, -Q_DIAG, 3, 0, -3, 20, 21));
        send_pose(mk_pose('0, Q_DIAG, -Q_DIAG, '0, 32768, -32768, 32767, 22, 23));
        send_pose(mk_pose(Q_HALF, Q_HALF, Q_HALF, Q_HALF, POS_MAX, POS_MAX, POS_MAX, 24, 25));
        send_pose(mk_pose(-Q_HALF, Q_HALF, -Q_HALF, Q_HALF, POS_MIN, POS_MIN, POS_MIN, 26, 27));
        send_pose(mk_pose(Q_ONE, Q_ONE, Q_ONE, Q_ONE, POS_MAX, POS_MAX, POS_MAX, 28, 29));
        send_pose(mk_pose(Q_NEG, Q_NEG, Q_NEG, Q_NEG, POS_MIN, POS_MIN, POS_MIN, 30, 31));
        send_pose(mk_pose(Q_TOP, Q_TOP, Q_TOP, Q_TOP, POS_MIN, 1, -1, SEC_MAX, NSEC_TOP));
        send_pose(mk_pose(Q_BOT, Q_BOT, Q_BOT, Q_BOT, POS_MAX, -1, 1, SEC_MAX, '0));
        send_pose(mk_pose('0, '0, '0, '0, -1, 0, 1, '0, NSEC_ONE_SEC));
        send_pose(mk_pose(Q_ONE, '0, '0, '0, '0, '0, '0, SEC_MAX, NSEC_TOP));
        send_pose(mk_pose(Q_TOP, Q_BOT, Q_TOP, Q_BOT, 100, -100, 100, 32, 33));
    endtask

    initial
    begin
        bit gaps_on;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        idle_cycles($urandom_range(1, 19));
        gaps_on = 1'b1;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 100 == 0)
                gaps_on = ($urandom_range(2) != 0);
            if (i >= N_RANDOM - QUIET_TAIL)
                gaps_on = 1'b0;
            if (i == N_RANDOM / 4 || i == N_RANDOM / 2)
                drain();
            else if (gaps_on && $urandom_range(3) == 0)
                idle_cycles($urandom_range(1, 19));
            send_pose(random_pose());
        end
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (LAT + 4) @(posedge clk);
        if (sb.mismatch_cnt == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+src
src/qit_pkg.sv
src/qit_center.sv
src/quaternion_inverse_translate.sv
tb/quaternion_inverse_translate_tb.sv
